// ===== design/recursive_lock_with_wait_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the recursive lock core
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_LOCK_WITH_WAIT_QUEUE_CORE_DEFINES_SVH
`define RECURSIVE_LOCK_WITH_WAIT_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LWQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock core assertion failed");
// Next-cycle implication.
`define LWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock core assertion failed");
`else
`define LWQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LWQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/lwq_pkg.sv =====
// ----------------------------------------------------------------------------
// Recursive lock package
// Status codes, request codes and fixed field widths.
// ----------------------------------------------------------------------------
package lwq_pkg;

   localparam int ID_W   = 4;
   localparam int NEST_W = 8;

   localparam logic [NEST_W-1:0] NEST_MAX = 8'hFF;

   localparam logic FUNC_ACQUIRE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_NESTED   = 3'd1,
      ST_QUEUED   = 3'd2,
      ST_UNNESTED = 3'd3,
      ST_FREED    = 3'd4,
      ST_NOTHOLD  = 3'd5,
      ST_WAITING  = 3'd6,
      ST_OVERFLOW = 3'd7
   } status_type;

endpackage

// ===== design/lwq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/recursive_lock_with_wait_queue_core.sv =====
// ----------------------------------------------------------------------------
// Recursive lock with FIFO wait queue
// Recursive mutex with a nesting count and a first-in first-out queue of
// waiting thread ids held in a small RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  func, thread_id
//   rsp_      out         rsp_valid/rsp_stall  status, wake_valid, wake_id
//
// Each request beat is taken in S_IDLE, while the queue RAM reads the entry
// at the head pointer, and is resolved in S_EXEC, where the tail entry is
// written back. The registered RAM read is why these are separate steps.
// A result waiting in the output register does not block the next request
// beat; only the resolve step waits until that register is free.
// Reset is synchronous and clears the lock, the pointers and the waiting
// marks; the queue RAM itself is not cleared, as an entry is only read after
// it has been written.

`include "recursive_lock_with_wait_queue_core_defines.svh"

module recursive_lock_with_wait_queue_core #(
   parameter int THREADS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [3:0]            req_thread_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lwq_pkg::status_type   rsp_status,
   output logic                  rsp_wake_valid,
   output logic [3:0]            rsp_wake_id
);

   import lwq_pkg::*;

   localparam int PTR_W  = $clog2(THREADS);
   localparam int FILL_W = $clog2(THREADS + 1);
   localparam int MARKS  = 1 << ID_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Sequencer and latched request.
   state_type          state_ff, state_in;
   logic               func_ff;
   logic [ID_W-1:0]    tid_ff;

   // Lock state.
   logic               held_ff, held_in;
   logic [ID_W-1:0]    holder_ff, holder_in;
   logic [NEST_W-1:0]  nest_ff, nest_in;

   // Queue pointers and the per-thread waiting marks.
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [MARKS-1:0]   mark_ff, mark_in;

   // Output register.
   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic               wake_valid_ff, wake_valid_in;
   logic [ID_W-1:0]    wake_id_ff, wake_id_in;

   logic               req_take;
   logic               exec_go;
   logic               q_wr;
   logic [ID_W-1:0]    q_rd_data;
   logic               tid_beyond;
   logic               q_full;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // The resolve step may only run when the output register can take its
   // result this cycle.
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // The read port always looks at the head, so the oldest waiter's id is
   // ready in the cycle after the request beat is taken.
   lwq_ram #(
      .WIDTH (ID_W),
      .DEPTH (THREADS)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr),
      .wr_addr (tail_ff),
      .wr_data (tid_ff),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(THREADS - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign tid_beyond = ({{(32 - ID_W){1'b0}}, tid_ff} >= 32'(THREADS));
   assign q_full     = (fill_ff >= FILL_W'(THREADS));

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      holder_in     = holder_ff;
      nest_in       = nest_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      mark_in       = mark_ff;
      status_in     = status_ff;
      wake_valid_in = 1'b0;
      wake_id_in    = '0;
      q_wr          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
               if (func_ff == FUNC_ACQUIRE) begin
                  if (held_ff && (holder_ff == tid_ff)) begin
                     // Re-entry by the holder: count up, saturating.
                     if (nest_ff == NEST_MAX) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        nest_in   = nest_ff + NEST_W'(1);
                        status_in = ST_NESTED;
                     end
                  end else if (!held_ff) begin
                     // A free lock is granted, even to a thread that still
                     // has an entry in the queue.
                     held_in   = 1'b1;
                     holder_in = tid_ff;
                     nest_in   = NEST_W'(1);
                     status_in = ST_GRANTED;
                  end else if (tid_beyond || mark_ff[tid_ff] || q_full) begin
                     status_in = ST_WAITING;
                  end else begin
                     q_wr            = 1'b1;
                     tail_in         = next_slot(tail_ff);
                     fill_in         = fill_ff + FILL_W'(1);
                     mark_in[tid_ff] = 1'b1;
                     status_in       = ST_QUEUED;
                  end
               end else begin
                  if (!held_ff || (holder_ff != tid_ff)) begin
                     status_in = ST_NOTHOLD;
                  end else if (nest_ff > NEST_W'(1)) begin
                     nest_in   = nest_ff - NEST_W'(1);
                     status_in = ST_UNNESTED;
                  end else begin
                     // Final release frees the lock and wakes the oldest
                     // waiter, which has to ask again.
                     held_in   = 1'b0;
                     holder_in = '0;
                     nest_in   = '0;
                     status_in = ST_FREED;
                     if (fill_ff != '0) begin
                        head_in            = next_slot(head_ff);
                        fill_in            = fill_ff - FILL_W'(1);
                        mark_in[q_rd_data] = 1'b0;
                        wake_valid_in      = 1'b1;
                        wake_id_in         = q_rd_data;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= 1'b0;
         holder_ff    <= '0;
         nest_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         holder_ff <= holder_in;
         nest_ff   <= nest_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
         mark_ff   <= mark_in;
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request latch and result payload carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_func;
         tid_ff  <= req_thread_id;
      end
      if (exec_go) begin
         status_ff     <= status_in;
         wake_valid_ff <= wake_valid_in;
         wake_id_ff    <= wake_id_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_wake_valid = wake_valid_ff;
   assign rsp_wake_id    = wake_id_ff;

   // A wake only ever comes with a final release.
   `LWQ_ASSERT_IMPLY(a_wake_freed, clock, reset, rsp_valid_ff && wake_valid_ff,
      status_ff == ST_FREED)
   // A free lock carries no nesting.
   `LWQ_ASSERT_IMPLY(a_free_no_nest, clock, reset, !held_ff, nest_ff == '0)
   // Every queued entry has exactly one waiting mark.
   `LWQ_ASSERT_IMPLY(a_marks_fill, clock, reset, 1'b1,
      $countones(mark_ff) == 32'(fill_ff))
   // The queue never holds more entries than it has slots.
   `LWQ_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(THREADS))
   // A taken request beat always moves to the resolve step.
   `LWQ_ASSERT_NEXT(a_take_exec, clock, reset, req_take, state_ff == S_EXEC)

endmodule

// ===== tb/sv/tb_recursive_lock_with_wait_queue_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the recursive lock core with FIFO wait queue
// Drives lock and unlock requests through the req_ channel with random gaps.
// Each result comes from the bench's model of the lock, nesting count and queue
// of waiters, or from the script where typed; rsp_ beats are compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_recursive_lock_with_wait_queue_core;

   import lwq_pkg::*;

   localparam int THREADS      = 16;
   localparam int QUIET_LIMIT  = 4000;  // cycles without any beat before giving up
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off used to fill the core
   localparam int DRAIN_CYCLES = 16;    // settle time once the last result has arrived

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // One result beat as the core reports it.
   typedef struct packed {
      status_type  status;
      logic        wake_valid;
      logic [3:0]  wake_id;
   } lock_result_type;

   // One row of the directed script. Where typed is set, the result is written
   // out by hand; otherwise it comes from the lock model.
   typedef struct packed {
      logic             func;
      logic [3:0]       tid;
      logic             typed;
      lock_result_type  result;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_ACQUIRE;
   logic [3:0]  req_thread_id = 4'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   status_type  rsp_status;
   logic        rsp_wake_valid;
   logic [3:0]  rsp_wake_id;

   // Lock model: who holds the lock, how deeply, and the queue of waiters.
   logic        lk_held;
   logic [3:0]  lk_owner;
   logic [7:0]  lk_depth;
   logic [3:0]  waitq [THREADS];
   logic [3:0]  wq_head;
   logic [3:0]  wq_tail;
   logic [4:0]  wq_fill;
   logic [15:0] waiting;

   lock_result_type pending_results [$];
   logic [3:0]      rejoin_q [$];      // woken threads that still have to ask again

   int send_idle_pct = 35;
   int recv_idle_pct = 85;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int failures      = 0;

   // The directed script walks through grant, nesting, queueing, duplicate
   // waits, foreign releases, wake-ups and a waiter taking a free lock.
   script_row_type script [25] = '{
      '{FUNC_ACQUIRE, 4'd0,  TYPED,     '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd0,  TYPED,     '{ST_FREED,    1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd15, TYPED,     '{ST_NOTHOLD,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd15, TYPED,     '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd3,  TYPED,     '{ST_QUEUED,   1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd3,  TYPED,     '{ST_WAITING,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd3,  TYPED,     '{ST_NOTHOLD,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd15, TYPED,     '{ST_FREED,    1'b1, 4'd3}},
      '{FUNC_ACQUIRE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd3,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd12, PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd7,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd12, PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd0,  PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd0,  TYPED,     '{ST_NOTHOLD,  1'b0, 4'd0}},
      '{FUNC_ACQUIRE, 4'd10, PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd10, PREDICTED, '{ST_GRANTED,  1'b0, 4'd0}},
      '{FUNC_RELEASE, 4'd15, TYPED,     '{ST_NOTHOLD,  1'b0, 4'd0}}
   };

   recursive_lock_with_wait_queue_core #(
      .THREADS        (THREADS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_thread_id  (req_thread_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_wake_valid (rsp_wake_valid),
      .rsp_wake_id    (rsp_wake_id)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Bring the lock model to its reset state: free, count zero, nobody waiting.
   function automatic void clear_lock_model();
      lk_held  = 1'b0;
      lk_owner = 4'd0;
      lk_depth = 8'd0;
      wq_head  = 4'd0;
      wq_tail  = 4'd0;
      wq_fill  = 5'd0;
      waiting  = 16'd0;
      for (int i = 0; i < THREADS; i++) begin
         waitq[i] = 4'd0;
      end
   endfunction

   // Apply one request to the lock model and return the result it calls for.
   // The 4-bit queue pointers wrap by themselves, as the queue has sixteen slots.
   function automatic lock_result_type resolve_request(logic func, logic [3:0] tid);
      lock_result_type res;
      res.status     = ST_GRANTED;
      res.wake_valid = 1'b0;
      res.wake_id    = 4'd0;
      if (func == FUNC_ACQUIRE) begin
         if (lk_held && lk_owner == tid) begin
            // The holder nests; the count sticks at its ceiling.
            if (lk_depth == NEST_MAX) begin
               res.status = ST_OVERFLOW;
            end else begin
               lk_depth   = lk_depth + 8'd1;
               res.status = ST_NESTED;
            end
         end else if (!lk_held) begin
            // A free lock goes to whoever asks, even a thread still queued.
            lk_held    = 1'b1;
            lk_owner   = tid;
            lk_depth   = 8'd1;
            res.status = ST_GRANTED;
         end else if (waiting[tid] || wq_fill == 5'(THREADS)) begin
            res.status = ST_WAITING;
         end else begin
            waitq[wq_tail] = tid;
            wq_tail        = wq_tail + 4'd1;
            wq_fill        = wq_fill + 5'd1;
            waiting[tid]   = 1'b1;
            res.status     = ST_QUEUED;
         end
      end else begin
         if (!lk_held || lk_owner != tid) begin
            res.status = ST_NOTHOLD;
         end else if (lk_depth > 8'd1) begin
            lk_depth   = lk_depth - 8'd1;
            res.status = ST_UNNESTED;
         end else begin
            // Final release: the lock is freed and the oldest waiter is woken.
            lk_held  = 1'b0;
            lk_owner = 4'd0;
            lk_depth = 8'd0;
            if (wq_fill != 5'd0) begin
               res.wake_valid   = 1'b1;
               res.wake_id      = waitq[wq_head];
               wq_head          = wq_head + 4'd1;
               wq_fill          = wq_fill - 5'd1;
               waiting[res.wake_id] = 1'b0;
            end
            res.status = ST_FREED;
         end
      end
      return res;
   endfunction

   // Offer one request beat and hold it until the core takes it. Once taken,
   // the expected result is queued, either the one typed into the script or
   // the one from the lock model, and the sender may then go quiet for a while.
   // Valid is only lowered when a gap follows, so it never drops and rises in
   // the same time step.
   task automatic drive_request(input logic func, input logic [3:0] tid,
                                input logic typed, input lock_result_type typed_res);
      lock_result_type res;
      req_valid     <= 1'b1;
      req_func      <= func;
      req_thread_id <= tid;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      res = resolve_request(func, tid);
      pending_results.push_back(typed ? typed_res : res);
      if (res.wake_valid && rejoin_q.size() < THREADS) begin
         rejoin_q.push_back(res.wake_id);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Mostly well-formed traffic: the holder releases or nests, other threads
   // contend and queue, and woken threads come back to ask again. About one
   // request in eight is noise with a random operation and thread.
   task automatic drive_random_request();
      int          pick;
      logic        func;
      logic [3:0]  tid;
      pick = $urandom_range(0, 99);
      func = FUNC_ACQUIRE;
      tid  = 4'($urandom_range(0, 15));
      if (pick < 12) begin
         func = ($urandom_range(0, 1) == 1) ? FUNC_RELEASE : FUNC_ACQUIRE;
      end else if (lk_held) begin
         if (pick < 50) begin
            func = FUNC_RELEASE;
            tid  = lk_owner;
         end else if (pick < 60) begin
            tid = lk_owner;
         end
      end else if (rejoin_q.size() != 0 && pick < 75) begin
         tid = rejoin_q.pop_front();
      end
      drive_request(func, tid, PREDICTED, '0);
   endtask

   // Drive one thread's nesting count up to its ceiling and a few beats past
   // it, with the odd contending acquire, then unwind it down to the final
   // release. Foreign releases are sprinkled into the unwinding.
   task automatic nest_to_ceiling();
      logic [3:0] tid;
      tid = lk_held ? lk_owner : 4'($urandom_range(0, 15));
      while (!(lk_held && lk_owner == tid && lk_depth == NEST_MAX)) begin
         drive_request(FUNC_ACQUIRE, tid, PREDICTED, '0);
         if ($urandom_range(0, 15) == 0) begin
            drive_request(FUNC_ACQUIRE, 4'($urandom_range(0, 15)), PREDICTED, '0);
         end
      end
      repeat (3) begin
         drive_request(FUNC_ACQUIRE, tid, PREDICTED, '0);
      end
      while (lk_held && lk_owner == tid) begin
         drive_request(FUNC_RELEASE, tid, PREDICTED, '0);
         if ($urandom_range(0, 15) == 0) begin
            drive_request(FUNC_RELEASE, 4'($urandom_range(0, 15)), PREDICTED, '0);
         end
      end
   endtask

   // Wait with the request channel quiet until every expected result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Result side: random stall, or a long hold-off when one has been asked for.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Every result beat is checked against the oldest expectation.
   always @(posedge clock) begin : result_check
      lock_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: status %0d wake %0d id %0d",
                   rsp_status, rsp_wake_valid, rsp_wake_id);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_wake_valid !== want.wake_valid) begin
               $error("wake_valid mismatch: expected %0d, got %0d",
                      want.wake_valid, rsp_wake_valid);
               failures++;
            end
            if (rsp_wake_id !== want.wake_id) begin
               $error("wake_id mismatch: expected %0d, got %0d", want.wake_id, rsp_wake_id);
               failures++;
            end
         end
      end
   end

   // Watchdog: the run is given up when no beat moves on either channel for
   // a long time.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_lock_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed script, then random traffic with a slow receiver.
      foreach (script[i]) begin
         drive_request(script[i].func, script[i].tid, script[i].typed, script[i].result);
      end
      repeat (425) drive_random_request();

      // Now the sender is the slow side.
      send_idle_pct = 85;
      recv_idle_pct = 35;
      repeat (425) drive_random_request();

      // Full rate on both sides: run one count up to its ceiling, then hold the
      // receiver off for a long stretch while requests keep coming, so that the
      // core backs up and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      nest_to_ceiling();
      holds_asked = 1;
      repeat (40) drive_random_request();
      drain_results();
      repeat (100) drive_random_request();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/lwq_pkg.sv
design/lwq_ram.sv
design/recursive_lock_with_wait_queue_core.sv
tb/sv/tb_recursive_lock_with_wait_queue_core.sv
